@@ rtl/joint_pose_chain_update_assert.svh @@
// Assertion helpers for the pose chain block.
`ifndef JOINT_POSE_CHAIN_UPDATE_ASSERT_SVH
`define JOINT_POSE_CHAIN_UPDATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JPCU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JPCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jpcu_pkg.sv @@
package jpcu_pkg;

    localparam int ROT_W     = 18;   // rotation entry, Q1.16
    localparam int Q_W       = 32;   // joint value / translation, Q16.16
    localparam int OP_W      = 3;
    localparam int ANG_W     = 35;   // reduced angle, Q30
    localparam int CORDIC_W  = 34;   // CORDIC x/y, Q30
    localparam int TAB_LEN   = 24;
    localparam int TAB_IDX_W = 5;
    localparam int ATAN_W    = 30;
    localparam int ANG_FRAC  = 30;
    localparam int TRIG_SHIFT = ANG_FRAC - 16;

    localparam int IN_DATA_W = 32;
    localparam int IN_USER_W = 4;
    localparam int OUT_FIELDS_W = 9 * ROT_W + 3 * Q_W;
    localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_REV_X = 3'd0;
    localparam logic [OP_W-1:0] OP_REV_Y = 3'd1;
    localparam logic [OP_W-1:0] OP_REV_Z = 3'd2;
    localparam logic [OP_W-1:0] OP_PRI_X = 3'd3;
    localparam logic [OP_W-1:0] OP_PRI_Y = 3'd4;
    localparam logic [OP_W-1:0] OP_PRI_Z = 3'd5;

    localparam logic signed [ROT_W-1:0] ROT_ONE  = 18'sh10000;
    localparam logic signed [ROT_W-1:0] ROT_ZERO = 18'sh00000;
    localparam logic signed [ROT_W-1:0] ROT_MAX  = 18'sh1FFFF;
    localparam logic signed [ROT_W-1:0] ROT_MIN  = 18'sh20000;

    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TRANS,
        S_MOD,
        S_SIGN,
        S_WRAP,
        S_HALF,
        S_CORDIC,
        S_ROUND,
        S_ROW_A,
        S_ROW_B,
        S_ROW_W,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic trans_add;
        logic mod_step;
        logic sign;
        logic wrap;
        logic half;
        logic cordic_step;
        logic round;
        logic mul_a;
        logic mul_b;
        logic row_write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_rev;
        logic is_pri;
        logic mod_last;
        logic cordic_last;
        logic row_last;
    } t_status;

    // arctan(2^-i), Q30
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [TAB_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/jpcu_ctrl.sv @@
module jpcu_ctrl import jpcu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  logic    i_m_tready,
    output logic    o_m_tvalid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        n_m_valid  = r_m_valid && !i_m_tready;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.is_rev)      n_state = S_MOD;
                else if (i_status.is_pri) n_state = S_TRANS;
                else                      n_state = S_DONE;
            end
            S_TRANS: begin
                o_cmd.trans_add = 1'b1;
                n_state         = S_DONE;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_last) n_state = S_SIGN;
            end
            S_SIGN: begin
                o_cmd.sign = 1'b1;
                n_state    = S_WRAP;
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_HALF;
            end
            S_HALF: begin
                o_cmd.half = 1'b1;
                n_state    = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_status.cordic_last) n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_ROW_A;
            end
            S_ROW_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_ROW_B;
            end
            S_ROW_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_ROW_W;
            end
            S_ROW_W: begin
                o_cmd.row_write = 1'b1;
                n_state         = i_status.row_last ? S_DONE : S_ROW_A;
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_m_valid;

endmodule

@@ rtl/jpcu_sincos.sv @@
module jpcu_sincos import jpcu_pkg::*; #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic signed [Q_W-1:0]   i_q,
    output logic                    o_mod_last,
    output logic                    o_cordic_last,
    output logic signed [ROT_W-1:0] o_sin,
    output logic signed [ROT_W-1:0] o_cos
);

    localparam int SH        = ANG_FRAC - FRACTION_BITS;
    localparam int MW        = Q_W + SH;
    localparam int K         = 29 - FRACTION_BITS;   // width of the 2*pi quotient
    localparam int RP        = 38;                   // reciprocal scale, 2^RP
    localparam int RCP_W     = RP + SH - 32;
    localparam longint RCP_L = (longint'(1) <<< (RP + SH)) / longint'(TWO_PI_Q30);
    localparam logic [RCP_W-1:0] RCP      = RCP_W'(RCP_L);
    localparam logic [MW-1:0]    TWO_PI_M = MW'($unsigned(TWO_PI_Q30));
    localparam int MOD_STEPS = 3;                    // quotient, subtract, correct
    localparam int NSTEP     = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int CNT_MAX   = (MOD_STEPS > NSTEP) ? MOD_STEPS : NSTEP;
    localparam int CNT_W     = $clog2(CNT_MAX);

    logic [CNT_W-1:0]           r_cnt;
    logic [Q_W-1:0]             r_qa;
    logic [K-1:0]               r_quo;
    logic [MW-1:0]              r_mag;
    logic                       r_neg, r_flip;
    logic signed [ANG_W-1:0]    r_z;
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [ROT_W-1:0]    r_sin, r_cos;

    logic [Q_W-1:0]             q_abs;
    logic [Q_W+RCP_W-1:0]       quo_prod;
    logic [MW-1:0]              quo_mul;
    logic signed [ANG_W-1:0]    rem, at;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic [CORDIC_W-1:0]        x_abs, y_abs;
    logic [CORDIC_W:0]          x_rnd, y_rnd;
    logic                       x_neg, y_neg;

    assign q_abs    = i_q[Q_W-1] ? Q_W'(-i_q) : Q_W'(i_q);
    // quotient estimate from the reciprocal of 2*pi is low by at most one
    assign quo_prod = r_qa * RCP;
    assign quo_mul  = MW'(r_quo) * TWO_PI_M;
    assign rem      = signed'(r_mag[ANG_W-1:0]);
    assign dx       = r_y >>> r_cnt;
    assign dy       = r_x >>> r_cnt;
    assign at       = signed'({{(ANG_W-ATAN_W){1'b0}}, atan_q30(TAB_IDX_W'(r_cnt))});

    // round half away from zero; the quadrant flip only changes the sign
    assign x_abs = r_x[CORDIC_W-1] ? CORDIC_W'(-r_x) : CORDIC_W'(r_x);
    assign y_abs = r_y[CORDIC_W-1] ? CORDIC_W'(-r_y) : CORDIC_W'(r_y);
    assign x_rnd = ({1'b0, x_abs} + (CORDIC_W+1)'(1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
    assign y_rnd = ({1'b0, y_abs} + (CORDIC_W+1)'(1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
    assign x_neg = r_x[CORDIC_W-1] ^ r_flip;
    assign y_neg = r_y[CORDIC_W-1] ^ r_flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load || i_cmd.half) begin
            r_cnt <= '0;
        end else if (i_cmd.mod_step || i_cmd.cordic_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qa  <= q_abs;
            r_mag <= MW'(q_abs) << SH;
            r_neg <= i_q[Q_W-1];
        end
        if (i_cmd.mod_step) begin
            // step 0: quotient, step 1: subtract, step 2: one correction
            if (r_cnt == CNT_W'(0))      r_quo <= K'(quo_prod >> RP);
            else if (r_cnt == CNT_W'(1)) r_mag <= r_mag - quo_mul;
            else if (r_mag >= TWO_PI_M)  r_mag <= r_mag - TWO_PI_M;
        end
        if (i_cmd.sign) r_z <= r_neg ? -rem : rem;
        if (i_cmd.wrap) begin
            if (r_z > PI_Q30)        r_z <= r_z - TWO_PI_Q30;
            else if (r_z <= -PI_Q30) r_z <= r_z + TWO_PI_Q30;
        end
        if (i_cmd.half) begin
            r_x <= GAIN_Q30;
            r_y <= '0;
            if (r_z > HALF_PI_Q30) begin
                r_z    <= r_z - PI_Q30;
                r_flip <= 1'b1;
            end else if (r_z < -HALF_PI_Q30) begin
                r_z    <= r_z + PI_Q30;
                r_flip <= 1'b1;
            end else begin
                r_flip <= 1'b0;
            end
        end
        if (i_cmd.cordic_step) begin
            if (!r_z[ANG_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
        if (i_cmd.round) begin
            r_cos <= x_neg ? -signed'(ROT_W'(x_rnd)) : signed'(ROT_W'(x_rnd));
            r_sin <= y_neg ? -signed'(ROT_W'(y_rnd)) : signed'(ROT_W'(y_rnd));
        end
    end

    assign o_mod_last    = (r_cnt == CNT_W'(MOD_STEPS - 1));
    assign o_cordic_last = (r_cnt == CNT_W'(NSTEP - 1));
    assign o_sin         = r_sin;
    assign o_cos         = r_cos;

endmodule

@@ rtl/jpcu_pose.sv @@
module jpcu_pose import jpcu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [Q_W-1:0]   i_q,
    input  logic                    i_restart,
    input  logic signed [ROT_W-1:0] i_sin,
    input  logic signed [ROT_W-1:0] i_cos,
    output logic                    o_is_rev,
    output logic                    o_is_pri,
    output logic                    o_row_last,
    output logic [OUT_W-1:0]        o_data
);

    localparam int PROD_W = 2 * ROT_W;

    // rows circulate: row 0 is always the one being worked on
    logic signed [ROT_W-1:0]  r_rot [3][3];
    logic signed [Q_W-1:0]    r_trans [3];
    logic [1:0]               r_row;
    logic [OP_W-1:0]          r_op;
    logic signed [Q_W-1:0]    r_q;
    logic signed [PROD_W-1:0] r_p1, r_p2;
    logic signed [ROT_W-1:0]  r_new_a;
    logic [OUT_W-1:0]         r_out;

    logic [1:0]               ca, cb, tk;
    logic signed [ROT_W-1:0]  va, vb, new_b;
    logic signed [ROT_W-1:0]  row_new [3];
    logic signed [Q_W:0]      tsum;
    logic signed [Q_W-1:0]    tsat;

    function automatic logic signed [ROT_W-1:0] rnd_sat(input logic signed [PROD_W:0] v);
        logic signed [PROD_W+1:0] w;
        logic signed [PROD_W-15:0] t;
        w = (PROD_W+2)'(v) + (v[PROD_W] ? (PROD_W+2)'(32767) : (PROD_W+2)'(32768));
        t = (PROD_W-14)'(w >>> 16);
        if (t > (PROD_W-14)'(ROT_MAX))      return ROT_MAX;
        else if (t < (PROD_W-14)'(ROT_MIN)) return ROT_MIN;
        else                                return ROT_W'(t);
    endfunction

    always_comb begin
        unique case (r_op)
            OP_REV_X: begin ca = 2'd1; cb = 2'd2; end
            OP_REV_Y: begin ca = 2'd2; cb = 2'd0; end
            default:  begin ca = 2'd0; cb = 2'd1; end
        endcase
    end

    assign va    = r_rot[0][ca];
    assign vb    = r_rot[0][cb];
    assign new_b = rnd_sat((PROD_W+1)'(r_p1) - (PROD_W+1)'(r_p2));

    always_comb begin
        row_new     = r_rot[0];
        row_new[ca] = r_new_a;
        row_new[cb] = new_b;
    end

    assign tk   = 2'(r_op - OP_PRI_X);
    assign tsum = (Q_W+1)'(r_trans[tk]) + (Q_W+1)'(r_q);
    assign tsat = (tsum[Q_W] != tsum[Q_W-1]) ? {tsum[Q_W], {(Q_W-1){~tsum[Q_W]}}}
                                             : tsum[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) r_rot[r][c] <= (r == c) ? ROT_ONE : ROT_ZERO;
                r_trans[r] <= '0;
            end
            r_row <= '0;
        end else begin
            if (i_cmd.load) begin
                r_row <= '0;
                if (i_restart) begin
                    for (int r = 0; r < 3; r++) begin
                        for (int c = 0; c < 3; c++)
                            r_rot[r][c] <= (r == c) ? ROT_ONE : ROT_ZERO;
                        r_trans[r] <= '0;
                    end
                end
            end
            if (i_cmd.trans_add) r_trans[tk] <= tsat;
            if (i_cmd.row_write) begin
                r_rot[0] <= r_rot[1];
                r_rot[1] <= r_rot[2];
                r_rot[2] <= row_new;
                r_row    <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_q  <= i_q;
        end
        if (i_cmd.mul_a) begin
            r_p1 <= i_cos * va;
            r_p2 <= i_sin * vb;
        end
        if (i_cmd.mul_b) begin
            r_new_a <= rnd_sat((PROD_W+1)'(r_p1) + (PROD_W+1)'(r_p2));
            r_p1    <= i_cos * vb;
            r_p2    <= i_sin * va;
        end
        if (i_cmd.out_load) begin
            r_out <= {{(OUT_W-OUT_FIELDS_W){1'b0}},
                      r_trans[2], r_trans[1], r_trans[0],
                      r_rot[2][2], r_rot[2][1], r_rot[2][0],
                      r_rot[1][2], r_rot[1][1], r_rot[1][0],
                      r_rot[0][2], r_rot[0][1], r_rot[0][0]};
        end
    end

    assign o_is_rev   = (r_op == OP_REV_X) || (r_op == OP_REV_Y) || (r_op == OP_REV_Z);
    assign o_is_pri   = (r_op == OP_PRI_X) || (r_op == OP_PRI_Y) || (r_op == OP_PRI_Z);
    assign o_row_last = (r_row == 2'd2);
    assign o_data     = r_out;

endmodule

@@ rtl/joint_pose_chain_update.sv @@
// Channel  Dir  Signals                         Contents
// s        in   i_s_tvalid/o_s_tready           one joint per transfer
//               i_s_tdata[31:0]                 q (Q16.16)
//               i_s_tuser[3:0]                  op[2:0], restart[3]
// m        out  o_m_tvalid/i_m_tready           whole pose per transfer
//               o_m_tdata[263:0]                r00..r22, px, py, pz
//
// Revolute joint: reciprocal 2*pi angle reduction (quotient, subtract, correct),
// the CORDIC iteration loop and rounding, then for each row of the rotation the
// two multiplies of the column update and the row write.
// Prismatic joint: one saturating translation add; unused op codes: pose unchanged.
// Reset (synchronous, active low) sets the pose to identity, zero translation.
// One item at a time; the next one is taken while the previous result still
// waits in the output register, and a stalled m side holds the block in the
// final state until that register frees up.
`include "joint_pose_chain_update_assert.svh"

module joint_pose_chain_update import jpcu_pkg::*; #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,   // [31:0] q
    input  logic [IN_USER_W-1:0] i_s_tuser,   // [2:0] op, [3] restart
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata    // r00,r01,r02,r10,r11,r12,r20,r21,r22
                                              // (18b each), px, py, pz (32b each), pad
);

    t_cmd    cmd;
    t_status status;

    logic signed [ROT_W-1:0] sin_v, cos_v;
    logic mod_last, cordic_last, is_rev, is_pri, row_last;

    // controller: sequences reduction, CORDIC, column update, translation add and output load
    jpcu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // angle reduction and CORDIC sine/cosine
    jpcu_sincos #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_sincos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_q           (signed'(i_s_tdata[Q_W-1:0])),
        .o_mod_last    (mod_last),
        .o_cordic_last (cordic_last),
        .o_sin         (sin_v),
        .o_cos         (cos_v)
    );

    // pose state, column rotation, translation add, output register
    jpcu_pose u_pose (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_op       (i_s_tuser[OP_W-1:0]),
        .i_q        (signed'(i_s_tdata[Q_W-1:0])),
        .i_restart  (i_s_tuser[OP_W]),
        .i_sin      (sin_v),
        .i_cos      (cos_v),
        .o_is_rev   (is_rev),
        .o_is_pri   (is_pri),
        .o_row_last (row_last),
        .o_data     (o_m_tdata)
    );

    always_comb begin
        status.is_rev      = is_rev;
        status.is_pri      = is_pri;
        status.mod_last    = mod_last;
        status.cordic_last = cordic_last;
        status.row_last    = row_last;
    end

    // one item in flight: no second transfer right after an accept
    `JPCU_ASSERT_NEXT(a_single_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "second input accepted while busy")
    // the output register is never overwritten while a result is pending
    `JPCU_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !o_m_tvalid || i_m_tready, "pending result overwritten")
    // last CORDIC iteration is followed by the rounding step
    `JPCU_ASSERT_NEXT(a_cordic_round, i_clk, i_rst_n, cmd.cordic_step && status.cordic_last, cmd.round, "CORDIC did not hand over to rounding")

endmodule
